@@ sv/ipdbf_pkg.sv @@
// ----------------------------------------------------------------------------
// ipdbf_pkg: shared definitions of the IPv4 destination blocklist filter
// Item codes, reason codes, table size, frame constants and the result type.
// ----------------------------------------------------------------------------
package ipdbf_pkg;

  // Table geometry. The entry index field is six bits wide, so every index
  // names a slot.
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = 6;
  localparam int CNT_W         = 64;

  // Result queue: room for one result per pipeline stage and the item on the
  // output port while a new item still comes in every cycle. A power of two,
  // so the pointers wrap by themselves.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Frame constants.
  localparam logic [15:0] IPV4_ETHERTYPE   = 16'h0800;
  localparam int          ETH_HDR_BYTES    = 14;
  localparam int          MIN_IP_HDR_BYTES = 20;
  localparam int          ETHERTYPE_HI_OFF = 12;
  localparam int          ETHERTYPE_LO_OFF = 13;
  localparam int          IHL_OFF          = 14;
  localparam int          DST_FIRST_OFF    = 30;
  localparam int          DST_LAST_OFF     = 33;

  // Item operation carried in tuser.
  typedef enum logic [1:0] {
    OP_FRAME_BYTE    = 2'd0,
    OP_WRITE_ENTRY   = 2'd1,
    OP_READ_COUNTERS = 2'd2
  } op_e;

  // Drop reason of a frame verdict.
  typedef enum logic [1:0] {
    REASON_NOT_LISTED = 2'd0,
    REASON_NOT_IPV4   = 2'd1,
    REASON_BAD_IP_HDR = 2'd2,
    REASON_BLOCKED    = 2'd3
  } reason_e;

  // Work carried down the pipeline.
  typedef enum logic [1:0] {
    ST_VERDICT = 2'd0,   // verdict settled by the header checks
    ST_LOOKUP  = 2'd1,   // verdict needs the table lookup
    ST_READ    = 2'd2,   // counter read
    ST_WRITE   = 2'd3    // table write, clears the counters in order
  } stg_e;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef struct packed {
    logic             kind;
    logic             verdict;
    reason_e          reason;
    logic             hit;
    logic [IDX_W-1:0] hit_index;
    logic [CNT_W-1:0] packet_count;
    logic [CNT_W-1:0] byte_count;
  } result_t;

endpackage

@@ sv/ipdbf_ram.sv @@
// ----------------------------------------------------------------------------
// ipdbf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ipdbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/ipv4_destination_blocklist_filter.sv @@
// ----------------------------------------------------------------------------
// ipv4_destination_blocklist_filter: drops IPv4 frames by destination address
// Streams Ethernet frames a byte per item, checks the headers, looks the
// destination up in a 64-slot blocklist and keeps per-slot drop counters.
// ----------------------------------------------------------------------------
// Usage
// The slave stream carries items: frame bytes in wire order (tlast on the
// final byte), table writes and counter reads, selected by tuser. The master
// stream returns one item per frame (the verdict, on the final byte) and one
// per counter read; table writes and non-final bytes return nothing.
// The result is registered: it passes the stage 1, 2 and 3 registers and the
// result queue before it is valid on the master side. One item is accepted
// every cycle while the queue has room: the header checks run as the bytes pass,
// then the 64-way address compare, the priority encode with the counter RAM
// read, and the counter add take one pipeline stage each. Results of hits and
// reads go through the counter RAMs with a forwarding register so that an item
// sees the update made by the item just ahead of it.
// Results wait in an eight-entry queue. tready stays high as long as the queue
// plus the results still in the pipeline leave room, so a stalled receiver
// only stops the input once that room is used up; nothing is lost.
// Reset clears all valid bits, counters (through per-slot valid flags, no
// clearing pass), the frame capture state and the pipeline. The block is
// ready as soon as reset is released.
// ----------------------------------------------------------------------------
module ipv4_destination_blocklist_filter (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Slave side.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0 up: data_byte[7:0], entry_index[13:8],
  // entry_address[45:14], entry_valid[46], zero fill [47].
  input  logic [47:0]  s_axis_tdata,
  // tuser: op[1:0].
  input  logic [1:0]   s_axis_tuser,
  // tlast: last_byte.
  input  logic         s_axis_tlast,
  // Master side.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0 up: verdict[0], reason[2:1], hit[3], hit_index[9:4],
  // packet_count[73:10], byte_count[137:74], zero fill [143:138].
  output logic [143:0] m_axis_tdata,
  // tuser: response_kind[0].
  output logic [0:0]   m_axis_tuser
);

  import ipdbf_pkg::*;

  // --------------------------------------------------------------------------
  // Input unpacking.
  // --------------------------------------------------------------------------
  logic             s_acc;
  op_e              in_op;
  logic [7:0]       in_byte;
  logic [IDX_W-1:0] in_idx;
  logic [31:0]      in_addr;
  logic             in_valid_bit;

  assign s_acc        = s_axis_tvalid && s_axis_tready;
  assign in_op        = op_e'(s_axis_tuser);
  assign in_byte      = s_axis_tdata[7:0];
  assign in_idx       = s_axis_tdata[13:8];
  assign in_addr      = s_axis_tdata[45:14];
  assign in_valid_bit = s_axis_tdata[46];

  // --------------------------------------------------------------------------
  // Frame capture and header checks, evaluated on each frame byte.
  // --------------------------------------------------------------------------
  logic [15:0] off_q, off_d;
  logic [15:0] eth_q, eth_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [31:0] dst_q, dst_d;
  logic [15:0] frame_len;
  logic [5:0]  ip_bytes;
  logic [15:0] hdr_end;
  logic        chk_not_ipv4;
  logic        chk_bad_hdr;

  always_comb begin
    eth_d = eth_q;
    ihl_d = ihl_q;
    dst_d = dst_q;
    if (off_q == 16'(ETHERTYPE_HI_OFF)) begin
      eth_d = {in_byte, eth_q[7:0]};
    end else if (off_q == 16'(ETHERTYPE_LO_OFF)) begin
      eth_d = {eth_q[15:8], in_byte};
    end else if (off_q == 16'(IHL_OFF)) begin
      ihl_d = in_byte[3:0];
    end else if (off_q >= 16'(DST_FIRST_OFF) && off_q <= 16'(DST_LAST_OFF)) begin
      dst_d = {dst_q[23:0], in_byte};
    end

    // The offset, and so the frame length, stops at its maximum.
    frame_len = (off_q != 16'hFFFF) ? off_q + 16'd1 : 16'hFFFF;
    off_d     = frame_len;

    ip_bytes = {ihl_d, 2'b00};
    hdr_end  = 16'(ETH_HDR_BYTES) + 16'(ip_bytes);

    chk_not_ipv4 = (frame_len < 16'(ETH_HDR_BYTES)) || (eth_d != IPV4_ETHERTYPE);
    chk_bad_hdr  = (frame_len < 16'(ETH_HDR_BYTES + MIN_IP_HDR_BYTES)) ||
                   (ip_bytes < 6'(MIN_IP_HDR_BYTES)) ||
                   (frame_len < hdr_end);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      eth_q <= '0;
      ihl_q <= '0;
      dst_q <= '0;
    end else if (s_acc && in_op == OP_FRAME_BYTE) begin
      if (s_axis_tlast) begin
        // Nothing of a finished frame carries over to the next one.
        off_q <= '0;
        eth_q <= '0;
        ihl_q <= '0;
        dst_q <= '0;
      end else begin
        off_q <= off_d;
        eth_q <= eth_d;
        ihl_q <= ihl_d;
        dst_q <= dst_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Blocklist table. Addresses and valid bits are flip-flops so that every
  // slot can be compared at once. Writes take effect at the accepting edge,
  // which keeps them in order with the compare one stage later.
  // --------------------------------------------------------------------------
  logic [31:0]              tbl_addr_q  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] tbl_valid_q;

  always_ff @(posedge clk_i) begin
    if (s_acc && in_op == OP_WRITE_ENTRY) begin
      tbl_addr_q[in_idx] <= in_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_valid_q <= '0;
    end else if (s_acc && in_op == OP_WRITE_ENTRY) begin
      tbl_valid_q[in_idx] <= in_valid_bit;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: checked frame or table operation.
  // --------------------------------------------------------------------------
  logic             s1_v_q, s1_v_d;
  stg_e             s1_op_q, s1_op_d;
  reason_e          s1_reason_q, s1_reason_d;
  logic [15:0]      s1_len_q;
  logic [31:0]      s1_dst_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic             s1_tv_q;

  always_comb begin
    s1_v_d      = 1'b0;
    s1_op_d     = ST_VERDICT;
    s1_reason_d = REASON_NOT_LISTED;
    if (s_acc) begin
      case (in_op)
        OP_FRAME_BYTE: begin
          if (s_axis_tlast) begin
            s1_v_d = 1'b1;
            if (chk_not_ipv4) begin
              s1_reason_d = REASON_NOT_IPV4;
            end else if (chk_bad_hdr) begin
              s1_reason_d = REASON_BAD_IP_HDR;
            end else begin
              s1_op_d = ST_LOOKUP;
            end
          end
        end
        OP_WRITE_ENTRY: begin
          s1_v_d  = 1'b1;
          s1_op_d = ST_WRITE;
        end
        OP_READ_COUNTERS: begin
          s1_v_d  = 1'b1;
          s1_op_d = ST_READ;
        end
        default: begin
          s1_v_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q     <= s1_op_d;
    s1_reason_q <= s1_reason_d;
    s1_len_q    <= frame_len;
    s1_dst_q    <= dst_d;
    s1_idx_q    <= in_idx;
    // The valid bit a counter read reports is the one in force when the read
    // item arrives.
    s1_tv_q     <= tbl_valid_q[in_idx];
  end

  // --------------------------------------------------------------------------
  // Stage 2: match vector of the parallel compare.
  // --------------------------------------------------------------------------
  logic [TABLE_ENTRIES-1:0] match;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = tbl_valid_q[i] && (tbl_addr_q[i] == s1_dst_q);
    end
  end

  logic                     s2_v_q;
  stg_e                     s2_op_q;
  reason_e                  s2_reason_q;
  logic [15:0]              s2_len_q;
  logic [IDX_W-1:0]         s2_idx_q;
  logic                     s2_tv_q;
  logic [TABLE_ENTRIES-1:0] s2_match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_op_q     <= s1_op_q;
    s2_reason_q <= s1_reason_q;
    s2_len_q    <= s1_len_q;
    s2_idx_q    <= s1_idx_q;
    s2_tv_q     <= s1_tv_q;
    s2_match_q  <= match;
  end

  // The lowest matching slot wins: isolate the lowest set bit, then encode.
  logic [TABLE_ENTRIES-1:0] first_hit;
  logic [IDX_W-1:0]         hit_enc;
  logic                     any_hit;
  logic [IDX_W-1:0]         ram_raddr;

  always_comb begin
    first_hit = s2_match_q & (~s2_match_q + TABLE_ENTRIES'(1));
    hit_enc   = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (first_hit[i]) begin
        hit_enc = hit_enc | IDX_W'(i);
      end
    end
    any_hit   = |s2_match_q;
    ram_raddr = (s2_op_q == ST_LOOKUP) ? hit_enc : s2_idx_q;
  end

  // --------------------------------------------------------------------------
  // Counter storage. A counter valid flag per slot stands for a zero value,
  // so reset and table writes clear a slot without touching the RAM.
  // --------------------------------------------------------------------------
  logic                     cnt_we;
  logic [IDX_W-1:0]         cnt_waddr;
  logic [CNT_W-1:0]         pk_wdata, bk_wdata;
  logic [CNT_W-1:0]         pk_rdata, bk_rdata;
  logic [TABLE_ENTRIES-1:0] cnt_valid_q;

  ipdbf_ram #(
    .WIDTH (CNT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_pkt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (pk_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (pk_rdata)
  );

  ipdbf_ram #(
    .WIDTH (CNT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (bk_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (bk_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 3: counter update and result.
  // --------------------------------------------------------------------------
  logic             s3_v_q;
  stg_e             s3_op_q;
  reason_e          s3_reason_q;
  logic [15:0]      s3_len_q;
  logic [IDX_W-1:0] s3_idx_q;
  logic             s3_tv_q;
  logic             s3_hit_q;
  logic             s3_cv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_op_q     <= s2_op_q;
    s3_reason_q <= s2_reason_q;
    s3_len_q    <= s2_len_q;
    s3_idx_q    <= ram_raddr;
    s3_tv_q     <= s2_tv_q;
    s3_hit_q    <= any_hit;
    s3_cv_q     <= cnt_valid_q[ram_raddr];
  end

  // The counter change made in the previous cycle is not yet visible in the
  // RAM read data or the sampled valid flag; this register carries it.
  logic             fwd_v_q, fwd_v_d;
  logic [IDX_W-1:0] fwd_idx_q;
  logic [CNT_W-1:0] fwd_pk_q, fwd_bk_q;

  logic [CNT_W-1:0] cur_pk, cur_bk;
  logic             cnt_set, cnt_clr;
  logic             push;
  result_t          push_res;

  always_comb begin
    if (fwd_v_q && fwd_idx_q == s3_idx_q) begin
      cur_pk = fwd_pk_q;
      cur_bk = fwd_bk_q;
    end else if (s3_cv_q) begin
      cur_pk = pk_rdata;
      cur_bk = bk_rdata;
    end else begin
      cur_pk = '0;
      cur_bk = '0;
    end

    pk_wdata  = cur_pk + CNT_W'(1);
    bk_wdata  = cur_bk + CNT_W'(s3_len_q);
    cnt_waddr = s3_idx_q;
    cnt_we    = 1'b0;
    cnt_set   = 1'b0;
    cnt_clr   = 1'b0;
    fwd_v_d   = 1'b0;
    push      = 1'b0;
    push_res  = '{kind: KIND_VERDICT, verdict: 1'b0, reason: REASON_NOT_LISTED,
                  hit: 1'b0, hit_index: '0, packet_count: '0, byte_count: '0};

    if (s3_v_q) begin
      case (s3_op_q)
        ST_VERDICT: begin
          push             = 1'b1;
          push_res.verdict = 1'b1;
          push_res.reason  = s3_reason_q;
        end
        ST_LOOKUP: begin
          push = 1'b1;
          if (s3_hit_q) begin
            cnt_we                = 1'b1;
            cnt_set               = 1'b1;
            fwd_v_d               = 1'b1;
            push_res.verdict      = 1'b1;
            push_res.reason       = REASON_BLOCKED;
            push_res.hit          = 1'b1;
            push_res.hit_index    = s3_idx_q;
            push_res.packet_count = pk_wdata;
            push_res.byte_count   = bk_wdata;
          end
        end
        ST_READ: begin
          push                  = 1'b1;
          push_res.kind         = KIND_READ;
          push_res.hit          = s3_tv_q;
          push_res.hit_index    = s3_idx_q;
          push_res.packet_count = cur_pk;
          push_res.byte_count   = cur_bk;
        end
        ST_WRITE: begin
          cnt_clr = 1'b1;
          fwd_v_d = 1'b1;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_valid_q <= '0;
      fwd_v_q     <= 1'b0;
    end else begin
      if (cnt_set) begin
        cnt_valid_q[s3_idx_q] <= 1'b1;
      end else if (cnt_clr) begin
        cnt_valid_q[s3_idx_q] <= 1'b0;
      end
      fwd_v_q <= fwd_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_idx_q <= s3_idx_q;
    fwd_pk_q  <= cnt_clr ? '0 : pk_wdata;
    fwd_bk_q  <= cnt_clr ? '0 : bk_wdata;
  end

  // --------------------------------------------------------------------------
  // Result queue and input credit.
  // --------------------------------------------------------------------------
  result_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] fifo_cnt_q;
  logic                  pop;
  logic [1:0]            n_pending;
  logic [FIFO_CNT_W-1:0] committed;

  assign pop = m_axis_tvalid && m_axis_tready;

  // Results still in the pipeline have a queue entry reserved for them.
  assign n_pending = 2'(s1_v_q && s1_op_q != ST_WRITE) +
                     2'(s2_v_q && s2_op_q != ST_WRITE) +
                     2'(s3_v_q && s3_op_q != ST_WRITE);
  assign committed = fifo_cnt_q + FIFO_CNT_W'(n_pending);

  assign s_axis_tready = committed < FIFO_CNT_W'(FIFO_DEPTH);

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        fifo_cnt_q <= fifo_cnt_q + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        fifo_cnt_q <= fifo_cnt_q - FIFO_CNT_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output packing.
  // --------------------------------------------------------------------------
  result_t head;

  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = fifo_cnt_q != '0;
  assign m_axis_tuser  = head.kind;
  assign m_axis_tdata  = {6'b0, head.byte_count, head.packet_count, head.hit_index,
                          head.hit, head.reason, head.verdict};

endmodule
